// ----- rtl/fba_pkg.sv -----
// Shared constants, codes and control types of the frame bitmap allocator.
// Used by fba_ctrl, fba_datapath and frame_bitmap_allocator; depends on nothing.
package fba_pkg;

    localparam int MAX_FRAMES_DEFAULT = 4096;

    localparam int FRAME_W    = 20;
    localparam int SIZE_W     = 13;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Bitmap storage: one memory word holds 32 frames, a byte holds 8.
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int BYTE_BITS  = 8;
    localparam int BYTE_SHIFT = 3;

    localparam logic [BYTE_BITS-1:0] BYTE_FULL  = 8'hFF;
    localparam logic [BYTE_BITS-1:0] FIRST_MARK = 8'h01;

    localparam logic [KIND_W-1:0] KIND_INIT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_FRAME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT = 3'd4;

    localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic capture;
        logic sweep_en;
        logic sweep_zero;
        logic scan_en;
        logic rel_read;
        logic rel_write;
        logic load_out;
    } fba_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic hit;
        logic miss;
        logic refuse;
        logic out_busy;
    } fba_stat_t;

endpackage

// ----- rtl/fba_ctrl.sv -----
// Controller of the frame bitmap allocator: sequences clearing, initialise,
// allocate and release transactions. Depends on fba_pkg.
module fba_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [fba_pkg::KIND_W-1:0]   kind,
    output logic                         in_ready,
    input  fba_pkg::fba_stat_t           stat,
    output fba_pkg::fba_cmd_t            cmd
);
    import fba_pkg::*;

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_INIT      = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_REL_CHECK = 3'd4;
    localparam logic [2:0] S_REL_WRITE = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_en   = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (kind)
                        KIND_INIT:    state_next = S_INIT;
                        KIND_ALLOC:   state_next = S_SCAN;
                        KIND_RELEASE: state_next = S_REL_CHECK;
                        KIND_UNUSED:  state_next = S_FINISH;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.sweep_en = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.hit || stat.miss)
                begin
                    state_next = S_FINISH;
                end
            end
            S_REL_CHECK:
            begin
                if (stat.refuse)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rel_read = 1'b1;
                    state_next   = S_REL_WRITE;
                end
            end
            S_REL_WRITE:
            begin
                cmd.rel_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/fba_datapath.sv -----
// Datapath of the frame bitmap allocator: configuration registers, the bitmap
// memory, the word scanner, release checks and the output register. Depends on fba_pkg.
module fba_datapath #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [fba_pkg::FRAME_W-1:0]      frame_number,
    input  fba_pkg::fba_cmd_t                cmd,
    output fba_pkg::fba_stat_t               stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fba_pkg::FRAME_W-1:0]      granted_frame,
    output logic                             found,
    output logic                             released
);
    import fba_pkg::*;

    localparam int DEPTH   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW      = $clog2(DEPTH + 1);
    localparam int LW      = $clog2(MAX_FRAMES + 1);
    localparam int SZW     = (LW > SIZE_W) ? LW : SIZE_W;
    localparam int IW      = AW + WORD_SHIFT;
    localparam int BPW     = WORD_BITS / BYTE_BITS;
    localparam int BSH     = $clog2(BPW);
    localparam int INIT_SW = FRAME_W - BYTE_SHIFT;
    localparam int INIT_EW = INIT_SW + 1;

    // Configuration registers.
    logic [FRAME_W-1:0] base_frame_reg;
    logic [SIZE_W-1:0]  pool_size_reg;
    logic [FRAME_W-1:0] info_frame_reg;
    logic [FRAME_W-1:0] reserved_base_reg;
    logic [SIZE_W-1:0]  reserved_count_reg;

    // Captured transaction and initialise pattern bounds.
    logic [FRAME_W-1:0] frame_reg;
    logic               init_ok_reg;
    logic               info_zero_reg;
    logic [INIT_SW-1:0] init_start_reg;
    logic [INIT_EW-1:0] init_end_reg;

    // Sequencing counters.
    logic [AW-1:0]      sweep_idx_reg;
    logic [NW-1:0]      issue_idx_reg;
    logic               inflight_valid_reg;
    logic [AW-1:0]      inflight_idx_reg;

    // Result staging and output register.
    logic [FRAME_W-1:0] res_grant_reg;
    logic               res_found_reg;
    logic               res_released_reg;
    logic               out_valid_reg;
    logic [FRAME_W-1:0] out_grant_reg;
    logic               out_found_reg;
    logic               out_released_reg;

    // Bitmap memory.
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [SZW-1:0]        pool_ext;
    logic [LW-1:0]         live_size;
    logic [NW-1:0]         full_words;
    logic [WORD_SHIFT-1:0] tail_bits;
    logic [NW-1:0]         nwords;
    logic                  issue_more;
    logic [WORD_BITS-1:0]  word_mask;
    logic [WORD_BITS-1:0]  free_bits;
    logic                  free_any;
    logic [WORD_SHIFT-1:0] free_pos;
    logic [IW-1:0]         grant_idx;
    logic                  hit;

    logic [FRAME_W-1:0]    map_frame;
    logic [FRAME_W:0]      res_end;
    logic [FRAME_W:0]      pool_end;
    logic [FRAME_W-1:0]    rel_diff;
    logic [IW-1:0]         rel_idx;
    logic [AW-1:0]         rel_word;
    logic [WORD_SHIFT-1:0] rel_bit;

    logic [FRAME_W-1:0]    init_diff;
    logic [WORD_BITS-1:0]  pattern;
    logic [AW+BSH-1:0]     byte_idx;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    // Pool geometry; a pool larger than the bitmap is clipped to it.
    assign pool_ext   = SZW'(pool_size_reg);
    assign live_size  = (pool_ext > SZW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(pool_ext);
    assign full_words = NW'(live_size >> WORD_SHIFT);
    assign tail_bits  = WORD_SHIFT'(live_size);
    assign nwords     = NW'(({1'b0, live_size} + (LW+1)'(WORD_BITS - 1)) >> WORD_SHIFT);
    assign issue_more = issue_idx_reg < nwords;

    // Lowest free frame of the word returned by the memory.
    always_comb
    begin
        if (NW'(inflight_idx_reg) < full_words)
        begin
            word_mask = '1;
        end
        else if (NW'(inflight_idx_reg) == full_words)
        begin
            word_mask = (WORD_BITS'(1) << tail_bits) - WORD_BITS'(1);
        end
        else
        begin
            word_mask = '0;
        end
        free_bits = ~rdata_reg & word_mask;
        free_any  = |free_bits;
        free_pos  = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (free_bits[k])
            begin
                free_pos = WORD_SHIFT'(k);
            end
        end
    end

    assign grant_idx = {inflight_idx_reg, free_pos};
    assign hit       = inflight_valid_reg && free_any;

    // Release checks; the bounds are taken one bit wider so that they do not wrap.
    assign map_frame = (info_frame_reg == '0) ? base_frame_reg : info_frame_reg;
    assign res_end   = {1'b0, reserved_base_reg} + (FRAME_W+1)'(reserved_count_reg);
    assign pool_end  = {1'b0, base_frame_reg} + (FRAME_W+1)'(live_size);
    assign rel_diff  = frame_reg - base_frame_reg;
    assign rel_idx   = IW'(rel_diff);
    assign rel_word  = rel_idx[IW-1:WORD_SHIFT];
    assign rel_bit   = rel_idx[WORD_SHIFT-1:0];

    assign stat.refuse = (frame_reg == map_frame)
                      || ((frame_reg >= reserved_base_reg) && ({1'b0, frame_reg} < res_end))
                      || (frame_reg < base_frame_reg)
                      || ({1'b0, frame_reg} >= pool_end);

    // Initialise pattern of the word under the sweep: whole reserved bytes,
    // and the first frame when the bitmap lives in the pool itself.
    assign init_diff = reserved_base_reg - base_frame_reg;

    always_comb
    begin
        pattern  = '0;
        byte_idx = '0;
        for (int m = 0; m < BPW; m++)
        begin
            byte_idx = {sweep_idx_reg, BSH'(m)};
            if (init_ok_reg && (INIT_EW'(byte_idx) >= INIT_EW'(init_start_reg))
                && (INIT_EW'(byte_idx) < init_end_reg))
            begin
                pattern[m*BYTE_BITS +: BYTE_BITS] = BYTE_FULL;
            end
        end
        if (info_zero_reg && (sweep_idx_reg == '0))
        begin
            pattern[BYTE_BITS-1:0] = pattern[BYTE_BITS-1:0] | FIRST_MARK;
        end
    end

    assign stat.sweep_last = (sweep_idx_reg == AW'(DEPTH - 1));
    assign stat.hit        = hit;
    assign stat.miss       = (nwords == '0)
                          || (inflight_valid_reg && !free_any
                              && (NW'(inflight_idx_reg) == nwords - NW'(1)));
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // Memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_idx_reg;
        wr_data = pattern;
        if (cmd.sweep_en)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_idx_reg;
            wr_data = cmd.sweep_zero ? '0 : pattern;
        end
        else if (cmd.scan_en && hit)
        begin
            wr_en   = 1'b1;
            wr_addr = inflight_idx_reg;
            wr_data = rdata_reg | (WORD_BITS'(1) << free_pos);
        end
        else if (cmd.rel_write)
        begin
            wr_en   = 1'b1;
            wr_addr = rel_word;
            wr_data = rdata_reg & ~(WORD_BITS'(1) << rel_bit);
        end
    end

    assign rd_en   = (cmd.scan_en && issue_more) || cmd.rel_read;
    assign rd_addr = cmd.rel_read ? rel_word : issue_idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_frame_reg     <= '0;
            pool_size_reg      <= POOL_SIZE_RESET;
            info_frame_reg     <= '0;
            reserved_base_reg  <= '0;
            reserved_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_FRAME:     base_frame_reg     <= cfg_data;
                REG_POOL_SIZE:      pool_size_reg      <= cfg_data[SIZE_W-1:0];
                REG_INFO_FRAME:     info_frame_reg     <= cfg_data;
                REG_RESERVED_BASE:  reserved_base_reg  <= cfg_data;
                REG_RESERVED_COUNT: reserved_count_reg <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control counters and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg      <= '0;
            issue_idx_reg      <= '0;
            inflight_valid_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                sweep_idx_reg <= '0;
            end
            else if (cmd.sweep_en)
            begin
                sweep_idx_reg <= stat.sweep_last ? '0 : sweep_idx_reg + AW'(1);
            end

            if (cmd.capture)
            begin
                issue_idx_reg      <= '0;
                inflight_valid_reg <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                inflight_valid_reg <= issue_more;
                if (issue_more)
                begin
                    issue_idx_reg <= issue_idx_reg + NW'(1);
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            frame_reg        <= frame_number;
            init_ok_reg      <= reserved_base_reg >= base_frame_reg;
            info_zero_reg    <= info_frame_reg == '0;
            init_start_reg   <= init_diff[FRAME_W-1:BYTE_SHIFT];
            init_end_reg     <= {1'b0, init_diff[FRAME_W-1:BYTE_SHIFT]}
                                + INIT_EW'(reserved_count_reg >> BYTE_SHIFT);
            res_grant_reg    <= '0;
            res_found_reg    <= 1'b0;
            res_released_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_en && hit)
            begin
                res_grant_reg <= base_frame_reg + FRAME_W'(grant_idx);
                res_found_reg <= 1'b1;
            end
            if (cmd.rel_write)
            begin
                res_released_reg <= 1'b1;
            end
        end

        if (cmd.scan_en && issue_more)
        begin
            inflight_idx_reg <= issue_idx_reg[AW-1:0];
        end

        if (cmd.load_out)
        begin
            out_grant_reg    <= res_grant_reg;
            out_found_reg    <= res_found_reg;
            out_released_reg <= res_released_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_frame = out_grant_reg;
    assign found         = out_found_reg;
    assign released      = out_released_reg;

endmodule

// ----- rtl/frame_bitmap_allocator.sv -----
// Top level of the frame bitmap allocator: joins the controller and the datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.

// One transaction is handled at a time, each giving exactly one result. The bitmap
// sits in a single-port-write memory of 32-frame words with a registered read, and
// that memory port sets the timing: an allocation reads one word per cycle and stops
// early when a free frame turns up; a release reads and rewrites a single word unless
// it is refused, and an initialise rewrites every word. After reset the block clears
// the bitmap before in_ready rises; configuration writes are taken throughout. A new
// transaction may be accepted while the previous result still waits in the output
// register.
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fba_pkg::KIND_W-1:0]       kind,
    input  logic [fba_pkg::FRAME_W-1:0]      frame_number,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fba_pkg::FRAME_W-1:0]      granted_frame,
    output logic                             found,
    output logic                             released
);
    import fba_pkg::*;

    fba_cmd_t  cmd;
    fba_stat_t stat;

    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frame_number  (frame_number),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_frame (granted_frame),
        .found         (found),
        .released      (released)
    );

`ifndef SYNTH
    // A result never reports both an allocation and a release.
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && released))
        else $error("result reports both found and released");

    // A result without a granted frame carries frame number zero.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (granted_frame == '0))
        else $error("granted frame not zero without an allocation");

    // Only one transaction is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in work");
`endif

endmodule
